### rtl/core/trilinear_table_interpolator_core_macros.svh
// Assertion macros for the trilinear table interpolator core.
`ifndef TRILINEAR_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`define TRILINEAR_TABLE_INTERPOLATOR_CORE_MACROS_SVH

`ifndef SYNTH
`define TTI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TTI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TTI_ASSERT_IMP(lbl, ante, cons, msg)
`define TTI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/tti_pkg.sv
package tti_pkg;

	localparam int MAX_POINTS_ONE   = 16;
	localparam int MAX_POINTS_TWO   = 16;
	localparam int MAX_POINTS_THREE = 16;
	localparam int MAX_VARS         = 8;

	localparam int MAX_POINTS_ALL =
		(MAX_POINTS_ONE > MAX_POINTS_TWO) ?
		((MAX_POINTS_ONE > MAX_POINTS_THREE) ? MAX_POINTS_ONE : MAX_POINTS_THREE) :
		((MAX_POINTS_TWO > MAX_POINTS_THREE) ? MAX_POINTS_TWO : MAX_POINTS_THREE);

	localparam int N_W  = $clog2(MAX_POINTS_ALL + 1);
	localparam int I_W  = $clog2(MAX_POINTS_ALL);
	localparam int I1_W = $clog2(MAX_POINTS_ONE);
	localparam int I2_W = $clog2(MAX_POINTS_TWO);
	localparam int I3_W = $clog2(MAX_POINTS_THREE);
	localparam int V_W  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
	localparam int NV_W = $clog2(MAX_VARS + 1);
	localparam int TA_W = I1_W + I2_W + I3_W + V_W;

	localparam int BASE_TWO   = MAX_POINTS_ONE;
	localparam int BASE_THREE = MAX_POINTS_ONE + MAX_POINTS_TWO;
	localparam int CDEPTH     = MAX_POINTS_ONE + MAX_POINTS_TWO + MAX_POINTS_THREE;
	localparam int CA_W       = $clog2(CDEPTH);

	localparam int W_W  = 17;
	localparam int Q_W  = 16;
	localparam int DV_W = 33;
	localparam logic [W_W-1:0] WONE = 17'h10000;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 5;

	typedef enum logic [1:0] {
		KIND_COORD = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PTS_ONE    = 3'd0,
		REG_PTS_TWO    = 3'd1,
		REG_PTS_THREE  = 3'd2,
		REG_VAR_COUNT  = 3'd3,
		REG_MODE_ONE   = 3'd4,
		REG_MODE_TWO   = 3'd5,
		REG_MODE_THREE = 3'd6
	} reg_idx_t;

	function automatic logic [N_W-1:0] clamp_pts(input logic [4:0] v, input int mx);
		if (v < 5'd2)
			return N_W'(2);
		if (int'(v) > mx)
			return N_W'(mx);
		return N_W'(v);
	endfunction

	function automatic logic [NV_W-1:0] clamp_vars(input logic [3:0] v);
		if (v < 4'd1)
			return NV_W'(1);
		if (int'(v) > MAX_VARS)
			return NV_W'(MAX_VARS);
		return NV_W'(v);
	endfunction

	// Computes w*a + (1-w)*b as b + w*(a-b), rounded to nearest with ties upward.
	function automatic logic signed [31:0] blend(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic [W_W-1:0] w);
		logic signed [32:0] d;
		logic signed [50:0] p;
		logic signed [51:0] s;
		logic signed [35:0] r;
		d = 33'(a) - 33'(b);
		p = d * $signed({1'b0, w});
		s = (52'(b) <<< 16) + 52'(p) + 52'sd32768;
		r = 36'(s >>> 16);
		if (r > 36'sd2147483647)
			return 32'sh7FFFFFFF;
		if (r < -36'sd2147483648)
			return 32'sh80000000;
		return 32'(r);
	endfunction

endpackage

### rtl/core/tti_if.sv
interface tti_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [1:0]         axis;
	logic [3:0]         point_index;
	logic [3:0]         grid_i;
	logic [3:0]         grid_j;
	logic [3:0]         grid_k;
	logic [3:0]         var_index;
	logic signed [31:0] load_value;
	logic signed [31:0] coord_a;
	logic signed [31:0] coord_b;
	logic signed [31:0] coord_c;

	modport source(output valid, kind, axis, point_index, grid_i, grid_j, grid_k,
		var_index, load_value, coord_a, coord_b, coord_c, input ready);
	modport sink(input valid, kind, axis, point_index, grid_i, grid_j, grid_k,
		var_index, load_value, coord_a, coord_b, coord_c, output ready);
endinterface

interface tti_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               status;

	modport source(output valid, result_value, status, input ready);
	modport sink(input valid, result_value, status, output ready);
endinterface

interface tti_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [4:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/tti_div.sv
module tti_div
	import tti_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DV_W-1:0] num,
	input  logic [DV_W-1:0] den,
	output logic            done,
	output logic [Q_W-1:0]  quo
);

	localparam int C_W = $clog2(Q_W + 1);

	logic [DV_W:0]   rem_q;
	logic [DV_W-1:0] den_q;
	logic [Q_W-1:0]  quo_q;
	logic [C_W-1:0]  cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DV_W:0]   shifted;

	assign shifted = {rem_q[DV_W-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= C_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - C_W'(1);
				if (cnt_q == C_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (shifted >= {1'b0, den_q}) begin
				rem_q <= shifted - {1'b0, den_q};
				quo_q <= {quo_q[Q_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[Q_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### rtl/core/trilinear_table_interpolator_core.sv
// Trilinear table interpolator. Load items fill the axis coordinate memory and the value table
// memory and are taken only while no query is in progress; there is no clearing pass after
// reset, so every coordinate and table entry a query touches must be loaded first. A query is
// handled one at a time: per axis, both ends of the axis are checked, then a bisection search
// of up to four steps (or, in uniform mode, a direct mapping) finds the cell, the cell ends are
// fetched, and an interior weight is computed in the shared bit-serial divider; then the eight
// corners are read from the table memory, with seven blends through one shared multiplier. A
// query with a bad variable number answers with an error status and a zero value. Results wait
// in an output register, and configuration writes are taken in every cycle.
`include "trilinear_table_interpolator_core_macros.svh"

module trilinear_table_interpolator_core
	import tti_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	tti_req_if.sink   req,
	tti_rsp_if.source rsp,
	tti_cfg_if.sink   cfg
);

	localparam int P_W = 32 + N_W + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_A0, S_A1, S_A2, S_BS, S_BW, S_P0, S_P1, S_P2, S_DV,
		S_TRD, S_TGT, S_B1, S_B2, S_B3, S_PUT
	} state_t;

	state_t state_q;

	logic [4:0]           pts_q [3];
	logic [3:0]           nvar_q;
	logic                 mode_q [3];

	logic signed [31:0]   c_q [3];
	logic [V_W-1:0]       var_q;
	logic [1:0]           ax_q;
	logic [I_W-1:0]       idx_q [3];
	logic [W_W-1:0]       w_q [3];
	logic [I_W-1:0]       blo_q;
	logic [I_W-1:0]       bhi_q;
	logic signed [31:0]   xi_q;
	logic [2:0]           corner_q;
	logic signed [31:0]   plo_q;
	logic signed [31:0]   f_q [2];
	logic signed [31:0]   g_q [2];
	logic signed [31:0]   res_q;
	logic                 rstat_q;
	logic signed [31:0]   out_val_q;
	logic                 out_stat_q;
	logic                 out_vld_q;

	logic signed [31:0]   cmem [CDEPTH];
	logic signed [31:0]   tmem [2**TA_W];
	logic signed [31:0]   cd_q;
	logic signed [31:0]   td_q;

	logic [N_W-1:0]       n_ax [3];
	logic [N_W-1:0]       n_cur;
	logic [NV_W-1:0]      nv;
	logic signed [31:0]   c_cur;
	logic [CA_W-1:0]      base_cur;
	logic [CA_W-1:0]      cmem_addr;
	logic [TA_W-1:0]      tmem_addr;
	logic [I_W-1:0]       mid;
	logic [I_W-1:0]       idx_cur;
	logic [I_W-1:0]       n_m1;
	logic [I_W-1:0]       n_m2;
	logic signed [P_W-1:0] prod;
	logic signed [P_W-1:0] qt;
	logic [I_W-1:0]       map_idx;
	logic signed [33:0]   num_w;
	logic signed [33:0]   den_w;
	logic                 div_start;
	logic                 div_done;
	logic [Q_W-1:0]       div_quo;
	logic signed [31:0]   bl_a;
	logic signed [31:0]   bl_b;
	logic [W_W-1:0]       bl_w;
	logic signed [31:0]   bl_out;
	logic                 req_acc;
	logic                 cw_en;
	logic [CA_W-1:0]      cw_addr;
	logic                 tw_en;
	logic [TA_W-1:0]      tw_addr;
	state_t               ax_done_state;

	assign req_acc = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign n_ax[0] = clamp_pts(pts_q[0], MAX_POINTS_ONE);
	assign n_ax[1] = clamp_pts(pts_q[1], MAX_POINTS_TWO);
	assign n_ax[2] = clamp_pts(pts_q[2], MAX_POINTS_THREE);
	assign nv      = clamp_vars(nvar_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q[0]  <= 5'd16;
			pts_q[1]  <= 5'd16;
			pts_q[2]  <= 5'd16;
			nvar_q    <= 4'd8;
			mode_q[0] <= 1'b0;
			mode_q[1] <= 1'b0;
			mode_q[2] <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PTS_ONE:    pts_q[0]  <= cfg.data;
				REG_PTS_TWO:    pts_q[1]  <= cfg.data;
				REG_PTS_THREE:  pts_q[2]  <= cfg.data;
				REG_VAR_COUNT:  nvar_q    <= cfg.data[3:0];
				REG_MODE_ONE:   mode_q[0] <= cfg.data[0];
				REG_MODE_TWO:   mode_q[1] <= cfg.data[0];
				REG_MODE_THREE: mode_q[2] <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ax_q)
			2'd1: begin
				c_cur    = c_q[1];
				base_cur = CA_W'(BASE_TWO);
			end
			2'd2: begin
				c_cur    = c_q[2];
				base_cur = CA_W'(BASE_THREE);
			end
			default: begin
				c_cur    = c_q[0];
				base_cur = '0;
			end
		endcase
	end

	always_comb begin
		case (ax_q)
			2'd1:    n_cur = n_ax[1];
			2'd2:    n_cur = n_ax[2];
			default: n_cur = n_ax[0];
		endcase
	end

	assign idx_cur = idx_q[ax_q];
	assign n_m1    = I_W'(n_cur - N_W'(1));
	assign n_m2    = I_W'(n_cur - N_W'(2));
	assign mid     = I_W'(((I_W+1)'(blo_q) + (I_W+1)'(bhi_q)) >> 1);

	always_comb begin
		case (state_q)
			S_A1:    cmem_addr = base_cur + CA_W'(n_m1);
			S_BS:    cmem_addr = base_cur + CA_W'(mid);
			S_P0:    cmem_addr = base_cur + CA_W'(idx_cur);
			S_P1:    cmem_addr = base_cur + CA_W'(idx_cur) + CA_W'(1);
			default: cmem_addr = base_cur;
		endcase
	end

	// Uniform mapping: cell = trunc(c*(n-1)) toward zero, held to 0..n-2.
	always_comb begin
		prod = c_cur * $signed({1'b0, n_m1});
		if (prod < 0)
			qt = (prod + P_W'(65535)) >>> 16;
		else
			qt = prod >>> 16;
		if (qt < 0)
			map_idx = '0;
		else if (qt > P_W'(n_m2))
			map_idx = n_m2;
		else
			map_idx = I_W'(qt);
	end

	assign num_w = 34'(cd_q) - 34'(c_cur);
	assign den_w = 34'(cd_q) - 34'(xi_q);
	assign div_start = (state_q == S_P2) && (den_w > 0) && (num_w > 0) && (num_w < den_w);

	tti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_w[DV_W-1:0]),
		.den    (den_w[DV_W-1:0]),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign tmem_addr = {I1_W'(idx_q[0] + I_W'(corner_q[0])),
		I2_W'(idx_q[1] + I_W'(corner_q[1])),
		I3_W'(idx_q[2] + I_W'(corner_q[2])), var_q};

	always_comb begin
		case (state_q)
			S_B1: begin
				bl_a = plo_q;
				bl_b = td_q;
				bl_w = w_q[0];
			end
			S_B2: begin
				bl_a = f_q[0];
				bl_b = f_q[1];
				bl_w = w_q[1];
			end
			default: begin
				bl_a = g_q[0];
				bl_b = g_q[1];
				bl_w = w_q[2];
			end
		endcase
	end

	assign bl_out = blend(bl_a, bl_b, bl_w);

	always_comb begin
		cw_en   = 1'b0;
		cw_addr = '0;
		if (req_acc && req.kind == KIND_COORD) begin
			case (req.axis)
				2'd0: begin
					cw_en   = int'(req.point_index) < MAX_POINTS_ONE;
					cw_addr = CA_W'(req.point_index);
				end
				2'd1: begin
					cw_en   = int'(req.point_index) < MAX_POINTS_TWO;
					cw_addr = CA_W'(BASE_TWO) + CA_W'(req.point_index);
				end
				2'd2: begin
					cw_en   = int'(req.point_index) < MAX_POINTS_THREE;
					cw_addr = CA_W'(BASE_THREE) + CA_W'(req.point_index);
				end
				default: cw_en = 1'b0;
			endcase
		end
	end

	assign tw_en = req_acc && req.kind == KIND_VALUE
		&& int'(req.grid_i) < MAX_POINTS_ONE && int'(req.grid_j) < MAX_POINTS_TWO
		&& int'(req.grid_k) < MAX_POINTS_THREE && int'(req.var_index) < MAX_VARS;
	assign tw_addr = {I1_W'(req.grid_i), I2_W'(req.grid_j), I3_W'(req.grid_k),
		V_W'(req.var_index)};

	always_ff @(posedge clk) begin
		if (cw_en)
			cmem[cw_addr] <= req.load_value;
		cd_q <= cmem[cmem_addr];
	end

	always_ff @(posedge clk) begin
		if (tw_en)
			tmem[tw_addr] <= req.load_value;
		td_q <= tmem[tmem_addr];
	end

	assign ax_done_state = (ax_q == 2'd2) ? S_TRD : S_A0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
			ax_q      <= '0;
			corner_q  <= '0;
		end else begin
			if (rsp.ready && state_q != S_PUT)
				out_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && req.kind == KIND_QUERY) begin
						c_q[0] <= req.coord_a;
						c_q[1] <= req.coord_b;
						c_q[2] <= req.coord_c;
						var_q  <= V_W'(req.var_index);
						ax_q   <= '0;
						if ({1'b0, req.var_index} >= 5'(nv)) begin
							res_q   <= '0;
							rstat_q <= 1'b1;
							state_q <= S_PUT;
						end else begin
							state_q <= S_A0;
						end
					end
				end
				S_A0: state_q <= S_A1;
				S_A1: begin
					if (c_cur <= cd_q) begin
						idx_q[ax_q] <= '0;
						w_q[ax_q]   <= WONE;
						ax_q        <= ax_q + 2'd1;
						corner_q    <= '0;
						state_q     <= ax_done_state;
					end else begin
						state_q <= S_A2;
					end
				end
				S_A2: begin
					if (c_cur >= cd_q) begin
						idx_q[ax_q] <= n_m2;
						w_q[ax_q]   <= '0;
						ax_q        <= ax_q + 2'd1;
						corner_q    <= '0;
						state_q     <= ax_done_state;
					end else if (!mode_q[ax_q]) begin
						blo_q   <= '0;
						bhi_q   <= n_m1;
						state_q <= S_BS;
					end else begin
						idx_q[ax_q] <= map_idx;
						state_q     <= S_P0;
					end
				end
				S_BS: begin
					if ((I_W+1)'(bhi_q) > (I_W+1)'(blo_q) + (I_W+1)'(1)) begin
						state_q <= S_BW;
					end else begin
						idx_q[ax_q] <= blo_q;
						state_q     <= S_P0;
					end
				end
				S_BW: begin
					if (c_cur >= cd_q)
						blo_q <= mid;
					else
						bhi_q <= mid;
					state_q <= S_BS;
				end
				S_P0: state_q <= S_P1;
				S_P1: begin
					xi_q    <= cd_q;
					state_q <= S_P2;
				end
				S_P2: begin
					if (div_start) begin
						state_q <= S_DV;
					end else begin
						w_q[ax_q] <= (den_w <= 0 || num_w > 0) ? WONE : '0;
						ax_q      <= ax_q + 2'd1;
						corner_q  <= '0;
						state_q   <= ax_done_state;
					end
				end
				S_DV: begin
					if (div_done) begin
						w_q[ax_q] <= {1'b0, div_quo};
						ax_q      <= ax_q + 2'd1;
						corner_q  <= '0;
						state_q   <= ax_done_state;
					end
				end
				S_TRD: state_q <= S_TGT;
				S_TGT: begin
					if (!corner_q[0]) begin
						plo_q    <= td_q;
						corner_q <= corner_q + 3'd1;
						state_q  <= S_TRD;
					end else begin
						state_q <= S_B1;
					end
				end
				S_B1: begin
					f_q[corner_q[1]] <= bl_out;
					if (!corner_q[1]) begin
						corner_q <= corner_q + 3'd1;
						state_q  <= S_TRD;
					end else begin
						state_q <= S_B2;
					end
				end
				S_B2: begin
					g_q[corner_q[2]] <= bl_out;
					if (!corner_q[2]) begin
						corner_q <= corner_q + 3'd1;
						state_q  <= S_TRD;
					end else begin
						state_q <= S_B3;
					end
				end
				S_B3: begin
					res_q   <= bl_out;
					rstat_q <= 1'b0;
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (!out_vld_q || rsp.ready) begin
						out_val_q  <= res_q;
						out_stat_q <= rstat_q;
						out_vld_q  <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.result_value = out_val_q;
	assign rsp.status       = out_stat_q;

	`TTI_ASSERT_IMP(a_div_done, div_done, state_q == S_DV, "Divider finished outside the divide state.")
	`TTI_ASSERT_IMP(a_weights, state_q == S_TRD, (w_q[0] <= WONE) && (w_q[1] <= WONE) && (w_q[2] <= WONE), "A weight exceeds one.")
	`TTI_ASSERT_IMP(a_bisect, state_q == S_BW, blo_q < bhi_q, "Bisection bounds crossed.")
	`TTI_ASSERT_IMP(a_bad_var, rsp.valid && rsp.status, rsp.result_value == '0, "Error word carries a nonzero value.")
	`TTI_ASSERT_NEXT(a_put, state_q == S_PUT && (!out_vld_q || rsp.ready), rsp.valid && state_q == S_IDLE, "Finished result was not presented.")

endmodule
